// ===== hdl/bdc_pkg.sv =====
// Shared types and constants for the button debounce / click detector.
// Holds the register map, the register reset values and the state and result words.
// No dependencies.
package bdc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_IS_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_TIMEOUT_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HELD_TIMEOUT_MS  = 3'd4;

  // register reset values
  localparam logic            RST_PRESSED_IS_HIGH  = 1'b0;
  localparam logic [MS_W-1:0] RST_DEBOUNCE_MS      = 16'd50;
  localparam logic [MS_W-1:0] RST_CLICK_TIMEOUT_MS = 16'd500;
  localparam logic [MS_W-1:0] RST_DOUBLE_CLICK_MS  = 16'd500;
  localparam logic [MS_W-1:0] RST_HELD_TIMEOUT_MS  = 16'd1000;

  typedef struct packed {
    logic            pressed_is_high;
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] click_timeout_ms;
    logic [MS_W-1:0] double_click_ms;
    logic [MS_W-1:0] held_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic              last_sample;
    logic              stable_state;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] first_click_time;
    logic              pending_clicks;
    logic              held_flag;
  } state_t;

  typedef struct packed {
    logic pressed_event;
    logic click_event;
    logic double_click_event;
    logic released_event;
    logic held_event;
    logic is_pressed;
    logic click_count;
  } result_t;

  localparam cfg_t CFG_RESET = '{
    pressed_is_high:  RST_PRESSED_IS_HIGH,
    debounce_ms:      RST_DEBOUNCE_MS,
    click_timeout_ms: RST_CLICK_TIMEOUT_MS,
    double_click_ms:  RST_DOUBLE_CLICK_MS,
    held_timeout_ms:  RST_HELD_TIMEOUT_MS
  };

endpackage

// ===== hdl/bdc_if.sv =====
// Valid/ready channel interfaces for sample words and event words.
// Depends on bdc_pkg for the time width.
interface bdc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         raw_level;
  logic [bdc_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bdc_out_if;
  logic valid;
  logic ready;
  logic pressed_event;
  logic click_event;
  logic double_click_event;
  logic released_event;
  logic held_event;
  logic is_pressed;
  logic click_count;

  modport source (output valid, output pressed_event, output click_event,
                  output double_click_event, output released_event, output held_event,
                  output is_pressed, output click_count, input ready);
  modport sink   (input valid, input pressed_event, input click_event,
                  input double_click_event, input released_event, input held_event,
                  input is_pressed, input click_count, output ready);
endinterface

// ===== hdl/bdc_eval.sv =====
// Next-state and event logic for one sample word.
// Pure combinational; depends on bdc_pkg for the state, config and result types.
module bdc_eval (
  input  bdc_pkg::cfg_t                cfg,
  input  bdc_pkg::state_t              st,
  input  logic                         raw_level,
  input  logic [bdc_pkg::TIME_W-1:0]   now_ms,
  output bdc_pkg::state_t              st_nxt,
  output bdc_pkg::result_t             res
);

  always_comb begin
    logic                       active;
    logic                       next_lvl;
    logic [bdc_pkg::TIME_W-1:0] dt_change;
    logic [bdc_pkg::TIME_W-1:0] dt_press;
    logic [bdc_pkg::TIME_W-1:0] dt_first;
    bdc_pkg::state_t            s;
    bdc_pkg::result_t           r;

    s = st;
    r = '0;
    active = (raw_level == cfg.pressed_is_high);

    // restart the debounce timer on any change
    if (active != s.last_sample) begin
      s.change_time = now_ms;
      s.last_sample = active;
    end
    dt_change = now_ms - s.change_time;
    next_lvl  = (dt_change >= {16'd0, cfg.debounce_ms}) ? s.last_sample : s.stable_state;

    dt_press = now_ms - st.press_time;
    dt_first = now_ms - st.first_click_time;
    if (next_lvl && !s.stable_state) begin
      s.stable_state  = 1'b1;
      s.press_time    = now_ms;
      r.pressed_event = 1'b1;
    end else if (!next_lvl && s.stable_state) begin
      s.stable_state = 1'b0;
      s.held_flag    = 1'b0;
      if (dt_press <= {16'd0, cfg.click_timeout_ms}) begin
        r.click_event = 1'b1;
        if (!s.pending_clicks) begin
          s.pending_clicks   = 1'b1;
          s.first_click_time = now_ms;
        end else begin
          s.pending_clicks     = 1'b0;
          r.double_click_event = (dt_first <= {16'd0, cfg.double_click_ms});
        end
      end else begin
        s.pending_clicks = 1'b0;
      end
      r.released_event = 1'b1;
    end

    // A stamp that just moved to now gives a zero difference, which never
    // passes a strict greater-than; skip those cases instead of subtracting again.
    if (s.stable_state) begin
      if (!s.held_flag && !r.pressed_event && (dt_press > {16'd0, cfg.held_timeout_ms})) begin
        s.held_flag  = 1'b1;
        r.held_event = 1'b1;
      end
    end else if (!(r.click_event && s.pending_clicks) &&
                 (dt_first > {16'd0, cfg.double_click_ms})) begin
      s.pending_clicks = 1'b0;
    end

    r.is_pressed  = s.stable_state;
    r.click_count = s.pending_clicks;
    st_nxt = s;
    res    = r;
  end

endmodule

// ===== hdl/button_debounce_click_detector.sv =====
// Button debouncer with pressed, click, double-click, released and held events.
// Sample words pass the input register, then the result register, to the event word.
// Throughput: one sample word per cycle unless stalled; input register is skid stage.
// Reset (rst_n low, synchronous): both stages empty, state cleared, registers to defaults.
// Depends on bdc_pkg, bdc_in_if, bdc_out_if and bdc_eval.
module button_debounce_click_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  bdc_in_if.sink                          in_ch,
  bdc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // input stage
  logic                       s1_valid_r;
  logic                       s1_raw_r;
  logic [bdc_pkg::TIME_W-1:0] s1_now_r;

  // detector state and registers
  bdc_pkg::state_t  st_r;
  bdc_pkg::state_t  st_nxt;
  bdc_pkg::cfg_t    cfg_r;
  bdc_pkg::cfg_t    cfg_nxt;

  // result stage
  logic             out_valid_r;
  bdc_pkg::result_t out_res_r;
  bdc_pkg::result_t res_nxt;

  logic advance;
  logic in_ready;

  // Advance the input stage into the result register whenever the result
  // register is empty or being drained this cycle.
  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_ch.ready = in_ready;

  bdc_eval u_eval (
    .cfg       (cfg_r),
    .st        (st_r),
    .raw_level (s1_raw_r),
    .now_ms    (s1_now_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  // Register writes; indexes past the map are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bdc_pkg::REG_PRESSED_IS_HIGH:  cfg_nxt.pressed_is_high  = cfg_data[0];
        bdc_pkg::REG_DEBOUNCE_MS:      cfg_nxt.debounce_ms      = cfg_data;
        bdc_pkg::REG_CLICK_TIMEOUT_MS: cfg_nxt.click_timeout_ms = cfg_data;
        bdc_pkg::REG_DOUBLE_CLICK_MS:  cfg_nxt.double_click_ms  = cfg_data;
        bdc_pkg::REG_HELD_TIMEOUT_MS:  cfg_nxt.held_timeout_ms  = cfg_data;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  // Control and detector state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      cfg_r       <= bdc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      // commit state only when the word actually moves to the result register
      if (advance && s1_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers: hold while stalled, load on transfer.
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_raw_r <= in_ch.raw_level;
      s1_now_r <= in_ch.now_ms;
    end
    if (advance && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.pressed_event      = out_res_r.pressed_event;
  assign out_ch.click_event        = out_res_r.click_event;
  assign out_ch.double_click_event = out_res_r.double_click_event;
  assign out_ch.released_event     = out_res_r.released_event;
  assign out_ch.held_event         = out_res_r.held_event;
  assign out_ch.is_pressed         = out_res_r.is_pressed;
  assign out_ch.click_count        = out_res_r.click_count;

  // The result word on display must reflect the committed state.
  a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.is_pressed == st_r.stable_state &&
                     out_res_r.click_count == st_r.pending_clicks))
    else $error("event word disagrees with committed detector state");

  // A double click is always also a click.
  a_dbl_is_click: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.double_click_event |-> out_res_r.click_event)
    else $error("double click without click");

  // Held fires only while the debounced state is pressed.
  a_held_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.held_event |-> out_res_r.is_pressed)
    else $error("held event while released");

  // Reset empties both the input stage and the result stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

endmodule
